// ===== sv/owtr_pkg.sv =====
// Shared types and constants for the one-wire temperature reader.
package owtr_pkg;

    localparam int TIME_W   = 10;
    localparam int NUM_REGS = 7;
    localparam int IN_W     = 8;
    localparam int OUT_W    = 24;
    localparam int ADDR_W   = 5;

    // Configuration register indexes
    localparam int REG_RESET_LOW     = 0;
    localparam int REG_PRESENCE_WAIT = 1;
    localparam int REG_RESET_TAIL    = 2;
    localparam int REG_ZERO_LOW      = 3;
    localparam int REG_ONE_LOW       = 4;
    localparam int REG_BIT_SAMPLE    = 5;
    localparam int REG_SLOT_TAIL     = 6;

    localparam logic [TIME_W-1:0] RST_RESET_LOW     = 10'd500;
    localparam logic [TIME_W-1:0] RST_PRESENCE_WAIT = 10'd100;
    localparam logic [TIME_W-1:0] RST_RESET_TAIL    = 10'd400;
    localparam logic [TIME_W-1:0] RST_ZERO_LOW      = 10'd60;
    localparam logic [TIME_W-1:0] RST_ONE_LOW       = 10'd2;
    localparam logic [TIME_W-1:0] RST_BIT_SAMPLE    = 10'd5;
    localparam logic [TIME_W-1:0] RST_SLOT_TAIL     = 10'd55;

    // Bus command bytes, the poll-done value and the CRC polynomial
    localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
    localparam logic [7:0] CMD_CONVERT  = 8'h44;
    localparam logic [7:0] CMD_READ_SP  = 8'hBE;
    localparam logic [7:0] POLL_DONE    = 8'hFF;
    localparam logic [7:0] CRC_POLY     = 8'h8C;

    localparam logic signed [15:0] FAIL_TEMP = 16'shF810;   // -127.0 degrees

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_READY = 2'd1;
    localparam logic [1:0] ST_CRC_ERR   = 2'd2;

    typedef enum logic [1:0] {
        FUNC_TICK    = 2'd0,
        FUNC_CONVERT = 2'd1,
        FUNC_READ    = 2'd2,
        FUNC_NONE    = 2'd3
    } func_t;

    typedef enum logic [8:0] {
        PH_IDLE      = 9'b000000001,
        PH_RST_LOW   = 9'b000000010,
        PH_RST_WAIT  = 9'b000000100,
        PH_RST_TAIL  = 9'b000001000,
        PH_SLOT_LOW  = 9'b000010000,
        PH_SLOT_WAIT = 9'b000100000,
        PH_SLOT_TAIL = 9'b001000000,
        PH_ZERO_LOW  = 9'b010000000,
        PH_ZERO_REC  = 9'b100000000
    } phase_t;

    typedef enum logic [7:0] {
        SG_CONV_RESET = 8'b00000001,
        SG_CONV_SKIP  = 8'b00000010,
        SG_CONV_CMD   = 8'b00000100,
        SG_POLL       = 8'b00001000,
        SG_RD_RESET   = 8'b00010000,
        SG_RD_SKIP    = 8'b00100000,
        SG_RD_CMD     = 8'b01000000,
        SG_RD_DATA    = 8'b10000000
    } stage_t;

    typedef logic [NUM_REGS-1:0][TIME_W-1:0] cfg_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [15:0] temperature;
        logic               presence;
        logic               done_res;
        logic               busy_res;
        logic               drive_low;
    } res_t;

    // A zero time is treated as one microsecond
    function automatic logic [TIME_W-1:0] eff_time(input logic [TIME_W-1:0] t);
        return (t == '0) ? TIME_W'(1) : t;
    endfunction

endpackage

// ===== sv/onewire_temperature_reader_unit.sv =====
// A result passes through the input register, then the result register, before
// it is offered on the result stream.
// Throughput: one item per cycle, one sequencer step per item, unless results stall.
// Input is taken while a result waits, as long as the input register is free.
// Reset: synchronous active-low aresetn; timing registers return to defaults,
// sequencer idles with temperature -2032.
// Top level of the one-wire temperature reader.
module onewire_temperature_reader_unit
    import owtr_pkg::*;
#(
    parameter int SCRATCH_BYTES = 9
) (
    input  logic              aclk,
    input  logic              aresetn,
    // APB configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,  // [1:0] func, [2] line_level, rest zero
    // result stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata   // [0] drive_low, [1] busy_res, [2] done_res,
                                        // [3] presence, [19:4] temperature, [21:20] status
);

    cfg_t        cfg_reg;
    logic [2:0]  reg_idx;
    logic        wr_en;

    logic        in_valid_reg;
    func_t       in_func_reg;
    logic        in_level_reg;
    logic        out_valid_reg;
    res_t        out_res_reg;
    res_t        res;
    logic        advance;

    // register file
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg[REG_RESET_LOW]     <= RST_RESET_LOW;
            cfg_reg[REG_PRESENCE_WAIT] <= RST_PRESENCE_WAIT;
            cfg_reg[REG_RESET_TAIL]    <= RST_RESET_TAIL;
            cfg_reg[REG_ZERO_LOW]      <= RST_ZERO_LOW;
            cfg_reg[REG_ONE_LOW]       <= RST_ONE_LOW;
            cfg_reg[REG_BIT_SAMPLE]    <= RST_BIT_SAMPLE;
            cfg_reg[REG_SLOT_TAIL]     <= RST_SLOT_TAIL;
        end else if (wr_en && (32'(reg_idx) < NUM_REGS)) begin
            cfg_reg[reg_idx] <= pwdata[TIME_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (32'(reg_idx) < NUM_REGS) begin
            prdata = {{(32-TIME_W){1'b0}}, cfg_reg[reg_idx]};
        end
    end

    // pipeline control
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_func_reg  <= func_t'(s_tdata[1:0]);
            in_level_reg <= s_tdata[2];
        end
        if (advance) begin
            out_res_reg <= res;
        end
    end

    owtr_seq #(
        .SCRATCH_BYTES (SCRATCH_BYTES)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (advance),
        .func       (in_func_reg),
        .line_level (in_level_reg),
        .cfg        (cfg_reg),
        .res        (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_res_reg};

endmodule

// ===== sv/owtr_seq.sv =====
// Bus sequencer: state registers and one-item next-state logic.
module owtr_seq
    import owtr_pkg::*;
#(
    parameter int SCRATCH_BYTES = 9
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step_en,
    input  func_t      func,
    input  logic       line_level,
    input  cfg_t       cfg,
    output res_t       res
);

    localparam int BI_W = (SCRATCH_BYTES > 1) ? $clog2(SCRATCH_BYTES) : 1;
    localparam logic [BI_W-1:0] LAST_BYTE = BI_W'(SCRATCH_BYTES - 1);

    phase_t             phase_reg, phase_next;
    stage_t             stage_reg, stage_next;
    logic [TIME_W-1:0]  time_reg, time_next;
    logic [2:0]         bit_reg, bit_next;
    logic [BI_W-1:0]    byte_reg, byte_next;
    logic [7:0]         shift_reg, shift_next;
    logic [7:0]         check_reg, check_next;
    logic [7:0]         tlow_reg, tlow_next;
    logic [7:0]         thigh_reg, thigh_next;
    logic               pres_reg, pres_next;
    logic               chain_reg, chain_next;
    logic signed [15:0] temp_reg, temp_next;
    logic [1:0]         status_reg, status_next;

    logic       done;
    logic       start_bit;
    logic       bit_done;
    logic [7:0] sh;
    logic [7:0] crc;
    logic       reading;

    assign reading = (stage_reg == SG_POLL) || (stage_reg == SG_RD_DATA);

    always_comb begin
        phase_next  = phase_reg;
        stage_next  = stage_reg;
        time_next   = time_reg;
        bit_next    = bit_reg;
        byte_next   = byte_reg;
        shift_next  = shift_reg;
        check_next  = check_reg;
        tlow_next   = tlow_reg;
        thigh_next  = thigh_reg;
        pres_next   = pres_reg;
        chain_next  = chain_reg;
        temp_next   = temp_reg;
        status_next = status_reg;
        done        = 1'b0;
        start_bit   = 1'b0;
        bit_done    = 1'b0;
        sh          = reading ? shift_reg : {1'b0, shift_reg[7:1]};
        crc         = {1'b0, check_reg[7:1]} ^
                      (((check_reg[0] ^ line_level) == 1'b1) ? CRC_POLY : 8'h00);

        if (func == FUNC_TICK) begin
            if (phase_reg != PH_IDLE) begin
                if (time_reg > TIME_W'(1)) begin
                    time_next = time_reg - TIME_W'(1);
                end else begin
                    time_next = '0;
                    unique case (phase_reg)
                        PH_RST_LOW: begin
                            phase_next = PH_RST_WAIT;
                            time_next  = eff_time(cfg[REG_PRESENCE_WAIT]);
                        end
                        PH_RST_WAIT: begin
                            pres_next  = ~line_level;
                            phase_next = PH_RST_TAIL;
                            time_next  = eff_time(cfg[REG_RESET_TAIL]);
                        end
                        PH_RST_TAIL: begin
                            stage_next = (stage_reg == SG_RD_RESET) ? SG_RD_SKIP : SG_CONV_SKIP;
                            shift_next = CMD_SKIP_ROM;
                            bit_next   = '0;
                            start_bit  = 1'b1;
                        end
                        PH_SLOT_LOW: begin
                            phase_next = PH_SLOT_WAIT;
                            time_next  = eff_time(cfg[REG_BIT_SAMPLE]);
                        end
                        PH_SLOT_WAIT: begin
                            // sample the slot, LSB first; CRC runs over data bytes
                            if (reading) begin
                                shift_next = {line_level, shift_reg[7:1]};
                                if (stage_reg == SG_RD_DATA) begin
                                    check_next = crc;
                                end
                            end
                            phase_next = PH_SLOT_TAIL;
                            time_next  = eff_time(cfg[REG_SLOT_TAIL]);
                        end
                        PH_ZERO_LOW: begin
                            phase_next = PH_ZERO_REC;
                            time_next  = eff_time(cfg[REG_ONE_LOW]);
                        end
                        PH_SLOT_TAIL, PH_ZERO_REC: begin
                            bit_done = 1'b1;
                        end
                        default: begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                    endcase
                end
            end
        end else if (phase_reg == PH_IDLE) begin
            if (func == FUNC_CONVERT) begin
                chain_next = 1'b0;
                stage_next = SG_CONV_RESET;
                phase_next = PH_RST_LOW;
                time_next  = eff_time(cfg[REG_RESET_LOW]);
            end else if (func == FUNC_READ) begin
                chain_next = 1'b0;
                stage_next = SG_POLL;
                shift_next = '0;
                bit_next   = '0;
                start_bit  = 1'b1;
            end
        end

        // end of a bit slot
        if (bit_done) begin
            shift_next = sh;
            bit_next   = bit_reg + 3'd1;
            if (bit_reg != 3'd7) begin
                start_bit = 1'b1;
            end else begin
                unique case (stage_reg)
                    SG_CONV_SKIP: begin
                        stage_next = SG_CONV_CMD;
                        shift_next = CMD_CONVERT;
                        bit_next   = '0;
                        start_bit  = 1'b1;
                    end
                    SG_CONV_CMD: begin
                        if (chain_reg) begin
                            temp_next   = {thigh_reg, tlow_reg};
                            status_next = ST_OK;
                            chain_next  = 1'b0;
                        end
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                    SG_POLL: begin
                        if (sh == POLL_DONE) begin
                            stage_next = SG_RD_RESET;
                            phase_next = PH_RST_LOW;
                            time_next  = eff_time(cfg[REG_RESET_LOW]);
                        end else begin
                            temp_next   = FAIL_TEMP;
                            status_next = ST_NOT_READY;
                            chain_next  = 1'b0;
                            phase_next  = PH_IDLE;
                            done        = 1'b1;
                        end
                    end
                    SG_RD_SKIP: begin
                        stage_next = SG_RD_CMD;
                        shift_next = CMD_READ_SP;
                        bit_next   = '0;
                        start_bit  = 1'b1;
                    end
                    SG_RD_CMD: begin
                        stage_next = SG_RD_DATA;
                        byte_next  = '0;
                        check_next = '0;
                        shift_next = '0;
                        bit_next   = '0;
                        start_bit  = 1'b1;
                    end
                    SG_RD_DATA: begin
                        if (byte_reg == BI_W'(0)) tlow_next = sh;
                        if (byte_reg == BI_W'(1)) thigh_next = sh;
                        if (byte_reg >= LAST_BYTE) begin
                            if (check_reg == 8'h00) begin
                                // good scratchpad: chain a fresh conversion
                                chain_next = 1'b1;
                                stage_next = SG_CONV_RESET;
                                phase_next = PH_RST_LOW;
                                time_next  = eff_time(cfg[REG_RESET_LOW]);
                            end else begin
                                temp_next   = FAIL_TEMP;
                                status_next = ST_CRC_ERR;
                                chain_next  = 1'b0;
                                phase_next  = PH_IDLE;
                                done        = 1'b1;
                            end
                        end else begin
                            byte_next  = byte_reg + BI_W'(1);
                            shift_next = '0;
                            bit_next   = '0;
                            start_bit  = 1'b1;
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                endcase
            end
        end

        // open the next slot: read slots and one bits use the short low time
        if (start_bit) begin
            if (stage_next == SG_POLL || stage_next == SG_RD_DATA || shift_next[0]) begin
                phase_next = PH_SLOT_LOW;
                time_next  = eff_time(cfg[REG_ONE_LOW]);
            end else begin
                phase_next = PH_ZERO_LOW;
                time_next  = eff_time(cfg[REG_ZERO_LOW]);
            end
        end

        if (phase_next == PH_IDLE) begin
            time_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            stage_reg  <= SG_CONV_RESET;
            time_reg   <= '0;
            bit_reg    <= '0;
            byte_reg   <= '0;
            shift_reg  <= '0;
            check_reg  <= '0;
            tlow_reg   <= '0;
            thigh_reg  <= '0;
            pres_reg   <= 1'b0;
            chain_reg  <= 1'b0;
            temp_reg   <= FAIL_TEMP;
            status_reg <= ST_OK;
        end else if (step_en) begin
            phase_reg  <= phase_next;
            stage_reg  <= stage_next;
            time_reg   <= time_next;
            bit_reg    <= bit_next;
            byte_reg   <= byte_next;
            shift_reg  <= shift_next;
            check_reg  <= check_next;
            tlow_reg   <= tlow_next;
            thigh_reg  <= thigh_next;
            pres_reg   <= pres_next;
            chain_reg  <= chain_next;
            temp_reg   <= temp_next;
            status_reg <= status_next;
        end
    end

    // result reflects the state this item leaves
    always_comb begin
        res.drive_low   = (phase_next == PH_RST_LOW) || (phase_next == PH_SLOT_LOW) ||
                          (phase_next == PH_ZERO_LOW);
        res.busy_res    = (phase_next != PH_IDLE);
        res.done_res    = done;
        res.presence    = pres_next;
        res.temperature = temp_next;
        res.status      = status_next;
    end

endmodule

// ===== sv/owtr_chk.sv =====
// Port-level checks for the one-wire temperature reader, bound to the top level.
module owtr_chk
    import owtr_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    // no result is offered right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result offered after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // a finishing item leaves the sequencer idle
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2] |-> !m_tdata[1])
        else $error("done while still busy");

    // the bus is only pulled low inside a running sequence
    a_drive_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[1])
        else $error("bus driven while idle");

endmodule

bind onewire_temperature_reader_unit owtr_chk u_chk (.*);
